/* rtl/core/dns_name_text_to_wire_core_macros.svh */
// Assertion macros shared by the name encoder RTL.
// Depends on nothing; each user module provides signals named clock and reset.
`ifndef DNS_NAME_TEXT_TO_WIRE_CORE_MACROS_SVH
`define DNS_NAME_TEXT_TO_WIRE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DNW_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DNW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DNW_ASSERT_IMPLY(lbl, ante, cons)
`define DNW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/dnw_pkg.sv */
// Shared types and constants for the text-to-wire name encoder.
// No dependencies.
package dnw_pkg;

   localparam logic [7:0] MAX_NAME_BYTES  = 8'd255;
   localparam logic [5:0] MAX_LABEL_BYTES = 6'd63;
   localparam int         MAX_RESULTS     = 3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_EMPTY_LABEL = 3'd1;
   localparam logic [2:0] ST_LABEL_LONG  = 3'd2;
   localparam logic [2:0] ST_BITSTRING   = 3'd3;
   localparam logic [2:0] ST_ESC_MIX     = 3'd4;
   localparam logic [2:0] ST_ESC_BIG     = 3'd5;
   localparam logic [2:0] ST_NAME_LONG   = 3'd6;
   localparam logic [2:0] ST_INCOMPLETE  = 3'd7;

   localparam logic REG_FOLD_CASE = 1'b0;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_name;
      logic       no_char;
   } req_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] write_offset;
      logic [7:0] write_byte;
      logic       name_done;
      logic [2:0] status;
      logic [7:0] name_length;
      logic [7:0] label_total;
   } res_type;

   typedef struct packed {
      logic [1:0]                   count;
      res_type [MAX_RESULTS-1:0]    slot;
   } bundle_type;

endpackage

/* rtl/core/dnw_if.sv */
// Valid/ready channel interfaces for the name encoder: request and result.
// Standalone; field widths follow the encoder package.
interface dnw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_name;
   logic       no_char;

   modport source (output valid, char_byte, end_of_name, no_char, input ready);
   modport sink   (input valid, char_byte, end_of_name, no_char, output ready);
endinterface

interface dnw_rsp_if;
   logic       valid;
   logic       ready;
   logic       write_valid;
   logic [7:0] write_offset;
   logic [7:0] write_byte;
   logic       name_done;
   logic [2:0] status;
   logic [7:0] name_length;
   logic [7:0] label_total;
   logic       last;

   modport source (output valid, write_valid, write_offset, write_byte, name_done, status,
                   name_length, label_total, last, input ready);
   modport sink   (input valid, write_valid, write_offset, write_byte, name_done, status,
                   name_length, label_total, last, output ready);
endinterface

/* rtl/core/dnw_parse.sv */
// Parser state and per-character step: builds the bundle of up to three results.
// Depends on dnw_pkg and the assertion macro header.
`include "dns_name_text_to_wire_core_macros.svh"

module dnw_parse
   import dnw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fold_case,
   input  logic       take,
   input  req_type    item,
   output bundle_type bundle
);

   localparam logic [2:0] PH_NAME_START   = 3'd0;
   localparam logic [2:0] PH_LABEL_START  = 3'd1;
   localparam logic [2:0] PH_ORDINARY     = 3'd2;
   localparam logic [2:0] PH_FIRST_ESCAPE = 3'd3;
   localparam logic [2:0] PH_ESCAPE       = 3'd4;
   localparam logic [2:0] PH_ESC_DECIMAL  = 3'd5;

   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_AT       = 8'h40;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;
   localparam logic [9:0] ESC_BYTE_MAX = 10'd255;
   localparam logic [1:0] ESC_DIGITS  = 2'd3;

   logic [2:0] phase_ff, phase_in;
   logic [5:0] label_len_ff, label_len_in;
   logic [1:0] esc_digits_ff, esc_digits_in;
   logic [9:0] esc_value_ff, esc_value_in;
   logic [7:0] wire_used_ff, wire_used_in;
   logic [7:0] label_start_ff, label_start_in;
   logic [7:0] labels_seen_ff, labels_seen_in;
   logic       discard_ff, discard_in;

   // working copies of the state inside the step
   logic [2:0]  w_phase;
   logic [5:0]  w_len;
   logic [1:0]  w_digits;
   logic [9:0]  w_value;
   logic [7:0]  w_used;
   logic [7:0]  w_start;
   logic [7:0]  w_labels;
   logic [13:0] w_mul;
   logic        failed, finished;
   logic [2:0]  fail_code;
   logic        go_start, go_ord, go_esc, go_dec, go_push, go_dot, go_fin, go_root;
   logic [7:0]  push_val;
   logic        do_byte, do_patch, do_zero;
   logic [7:0]  byte_off, byte_val, patch_off;
   logic [5:0]  patch_len;
   logic [1:0]  cnt;
   logic [7:0]  c;
   logic        e, nc, is_digit;
   logic [3:0]  digit;

   function automatic logic [7:0] fold_byte(input logic [7:0] v, input logic en);
      logic [7:0] r;
      r = v;
      if (en && v >= CH_UPPER_A && v <= CH_UPPER_Z) begin
         r = v + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic res_type make_res(input logic wv, input logic [7:0] off,
                                        input logic [7:0] byt, input logic done,
                                        input logic [2:0] st, input logic [7:0] len,
                                        input logic [7:0] lab);
      res_type r;
      r.write_valid  = wv;
      r.write_offset = off;
      r.write_byte   = byt;
      r.name_done    = done;
      r.status       = st;
      r.name_length  = len;
      r.label_total  = lab;
      return r;
   endfunction

   always_comb begin
      c        = item.char_byte;
      e        = item.end_of_name;
      nc       = item.no_char;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      digit    = 4'(c - CH_ZERO);

      w_phase  = phase_ff;
      w_len    = label_len_ff;
      w_digits = esc_digits_ff;
      w_value  = esc_value_ff;
      w_used   = wire_used_ff;
      w_start  = label_start_ff;
      w_labels = labels_seen_ff;
      w_mul    = '0;

      failed    = 1'b0;
      finished  = 1'b0;
      fail_code = ST_OK;
      go_start  = 1'b0;
      go_ord    = 1'b0;
      go_esc    = 1'b0;
      go_dec    = 1'b0;
      go_push   = 1'b0;
      go_dot    = 1'b0;
      go_fin    = 1'b0;
      go_root   = 1'b0;
      push_val  = '0;
      do_byte   = 1'b0;
      do_patch  = 1'b0;
      do_zero   = 1'b0;
      byte_off  = '0;
      byte_val  = '0;
      patch_off = '0;
      patch_len = '0;

      if (!discard_ff && !nc) begin
         if (w_used >= MAX_NAME_BYTES) begin
            failed    = 1'b1;
            fail_code = ST_NAME_LONG;
         end else begin
            unique case (w_phase)
               PH_NAME_START: begin
                  if (c == CH_DOT) begin
                     if (e) begin
                        go_root = 1'b1;
                     end else begin
                        failed    = 1'b1;
                        fail_code = ST_EMPTY_LABEL;
                     end
                  end else if (c == CH_AT && e) begin
                     go_root = 1'b1;
                  end else begin
                     go_start = 1'b1;
                  end
               end
               PH_ORDINARY: go_ord = 1'b1;
               PH_FIRST_ESCAPE: begin
                  if (c == CH_LBRACKET) begin
                     failed    = 1'b1;
                     fail_code = ST_BITSTRING;
                  end else begin
                     go_esc = 1'b1;
                  end
               end
               PH_ESCAPE:      go_esc = 1'b1;
               PH_ESC_DECIMAL: go_dec = 1'b1;
               default:        go_start = 1'b1;
            endcase
         end

         // open a label: reserve its length slot
         if (go_start) begin
            w_start = w_used;
            w_used  = w_used + 8'd1;
            w_len   = '0;
            if (c == CH_BSLASH) begin
               w_phase = PH_FIRST_ESCAPE;
            end else begin
               w_phase = PH_ORDINARY;
               go_ord  = 1'b1;
            end
         end

         if (go_ord) begin
            if (c == CH_DOT) begin
               if (w_len == '0) begin
                  failed    = 1'b1;
                  fail_code = ST_EMPTY_LABEL;
               end else begin
                  go_dot = 1'b1;
               end
            end else if (c == CH_BSLASH) begin
               w_phase = PH_ESCAPE;
            end else begin
               go_push  = 1'b1;
               push_val = c;
            end
         end

         if (go_esc) begin
            if (!is_digit) begin
               go_push  = 1'b1;
               push_val = c;
            end else begin
               w_digits = '0;
               w_value  = '0;
               w_phase  = PH_ESC_DECIMAL;
               go_dec   = 1'b1;
            end
         end

         // accumulate one decimal digit of an escape
         if (go_dec) begin
            if (!is_digit) begin
               failed    = 1'b1;
               fail_code = ST_ESC_MIX;
            end else begin
               w_mul    = 14'(w_value) * 14'd10 + 14'(digit);
               w_value  = w_mul[9:0];
               w_digits = w_digits + 2'd1;
               if (w_digits == ESC_DIGITS) begin
                  w_digits = '0;
                  if (w_value > ESC_BYTE_MAX) begin
                     failed    = 1'b1;
                     fail_code = ST_ESC_BIG;
                  end else begin
                     go_push  = 1'b1;
                     push_val = w_value[7:0];
                  end
               end
            end
         end

         if (go_push) begin
            if ({1'b0, w_len} + 7'd1 > {1'b0, MAX_LABEL_BYTES}) begin
               failed    = 1'b1;
               fail_code = ST_LABEL_LONG;
            end else if (w_used >= MAX_NAME_BYTES) begin
               failed    = 1'b1;
               fail_code = ST_NAME_LONG;
            end else begin
               do_byte  = 1'b1;
               byte_off = w_used;
               byte_val = fold_byte(push_val, fold_case);
               w_used   = w_used + 8'd1;
               w_len    = w_len + 6'd1;
               w_phase  = PH_ORDINARY;
            end
         end

         if (go_dot) begin
            do_patch  = 1'b1;
            patch_off = w_start;
            patch_len = w_len;
            w_labels  = w_labels + 8'd1;
            if (e) begin
               do_zero  = 1'b1;
               finished = 1'b1;
            end else begin
               w_phase = PH_LABEL_START;
            end
         end

         if (go_root) begin
            finished = 1'b1;
         end
      end

      go_fin = !discard_ff && e && (nc || (!failed && !finished));
      if (go_fin) begin
         if (w_used >= MAX_NAME_BYTES) begin
            failed    = 1'b1;
            fail_code = ST_NAME_LONG;
         end else if (w_phase != PH_ORDINARY) begin
            failed    = 1'b1;
            fail_code = ST_INCOMPLETE;
         end else begin
            do_patch  = 1'b1;
            patch_off = w_start;
            patch_len = w_len;
            w_labels  = w_labels + 8'd1;
            do_zero   = 1'b1;
            finished  = 1'b1;
         end
      end

      // pack results in emission order
      cnt         = '0;
      bundle.slot = '0;
      if (do_byte) begin
         bundle.slot[cnt] = make_res(1'b1, byte_off, byte_val, 1'b0, ST_OK, 8'd0, 8'd0);
         cnt = cnt + 2'd1;
      end
      if (do_patch) begin
         bundle.slot[cnt] = make_res(1'b1, patch_off, {2'b00, patch_len}, 1'b0, ST_OK,
                                     8'd0, 8'd0);
         cnt = cnt + 2'd1;
      end
      if (do_zero) begin
         bundle.slot[cnt] = make_res(1'b1, w_used, 8'd0, 1'b1, ST_OK, w_used + 8'd1,
                                     w_labels + 8'd1);
         cnt = cnt + 2'd1;
      end
      if (failed) begin
         bundle.slot[cnt] = make_res(1'b0, 8'd0, 8'd0, 1'b1, fail_code, 8'd0, 8'd0);
         cnt = cnt + 2'd1;
      end
      if (go_root) begin
         bundle.slot[cnt] = make_res(1'b1, 8'd0, 8'd0, 1'b1, ST_OK, 8'd1, 8'd1);
         cnt = cnt + 2'd1;
      end
      bundle.count = cnt;

      // next state
      phase_in       = w_phase;
      label_len_in   = w_len;
      esc_digits_in  = w_digits;
      esc_value_in   = w_value;
      wire_used_in   = w_used;
      label_start_in = w_start;
      labels_seen_in = w_labels;
      discard_in     = discard_ff;
      if ((discard_ff && e) || (!discard_ff && (failed || finished || e))) begin
         phase_in       = PH_NAME_START;
         label_len_in   = '0;
         esc_digits_in  = '0;
         esc_value_in   = '0;
         wire_used_in   = '0;
         label_start_in = '0;
         labels_seen_in = '0;
         discard_in     = !discard_ff && failed && !e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NAME_START;
         label_len_ff   <= '0;
         esc_digits_ff  <= '0;
         esc_value_ff   <= '0;
         wire_used_ff   <= '0;
         label_start_ff <= '0;
         labels_seen_ff <= '0;
         discard_ff     <= 1'b0;
      end else if (take) begin
         phase_ff       <= phase_in;
         label_len_ff   <= label_len_in;
         esc_digits_ff  <= esc_digits_in;
         esc_value_ff   <= esc_value_in;
         wire_used_ff   <= wire_used_in;
         label_start_ff <= label_start_in;
         labels_seen_ff <= labels_seen_in;
         discard_ff     <= discard_in;
      end
   end

   `DNW_ASSERT_IMPLY(a_discard_at_start, discard_ff, phase_ff == PH_NAME_START && wire_used_ff == 8'd0 && labels_seen_ff == 8'd0)
   `DNW_ASSERT_NEXT(a_error_discards, take && !discard_ff && failed && !e, discard_ff)
   `DNW_ASSERT_IMPLY(a_label_bound, !discard_ff, label_len_ff <= MAX_LABEL_BYTES)

endmodule

/* rtl/core/dnw_drain.sv */
// Result register: holds one bundle and hands its results out one per cycle while rsp.ready is high.
// Depends on dnw_pkg, dnw_rsp_if and the assertion macro header.
`include "dns_name_text_to_wire_core_macros.svh"

module dnw_drain
   import dnw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bundle_type       bundle,
   output logic             can_load,
   dnw_rsp_if.source        rsp
);

   res_type [MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] index_ff, index_in;
   logic       pop, pop_last, at_last;
   res_type    cur;

   assign cur      = slot_ff[index_ff];
   assign at_last  = (index_ff == count_ff - 2'd1);
   assign pop      = rsp.valid && rsp.ready;
   assign pop_last = pop && at_last;
   assign can_load = (count_ff == 2'd0) || pop_last;

   assign rsp.valid        = (count_ff != 2'd0);
   assign rsp.write_valid  = cur.write_valid;
   assign rsp.write_offset = cur.write_offset;
   assign rsp.write_byte   = cur.write_byte;
   assign rsp.name_done    = cur.name_done;
   assign rsp.status       = cur.status;
   assign rsp.name_length  = cur.name_length;
   assign rsp.label_total  = cur.label_total;
   assign rsp.last         = at_last;

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         slot_in  = bundle.slot;
         count_in = bundle.count;
         index_in = '0;
      end else if (pop_last) begin
         count_in = '0;
         index_in = '0;
      end else if (pop) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   `DNW_ASSERT_IMPLY(a_done_is_last, rsp.valid && rsp.name_done, rsp.last)
   `DNW_ASSERT_IMPLY(a_nowrite_is_error, rsp.valid && !rsp.write_valid, rsp.name_done && rsp.status != ST_OK)
   `DNW_ASSERT_IMPLY(a_index_in_range, rsp.valid, index_ff < count_ff)

endmodule

/* rtl/core/dns_name_text_to_wire_core.sv */
// Text-to-wire DNS name encoder. Takes one character of a presentation-form name per item
// and returns wire-format byte writes: label bytes at their offsets, each label's length
// byte patched into the slot reserved at its start, then the trailing zero on a done result
// that carries total wire length and label count. Root is '.' or '@' alone; backslash
// escapes a character or a three-digit decimal byte; fold_case lowercases ASCII letters.
// Errors come back once as a status on a done result, and the rest of that name is dropped
// up to its end marker. Timing: an item is registered on acceptance, parsed combinationally
// into a bundle of zero to three results once the result register can take it, and that
// bundle is registered there to offer its first result. The single result port sets the
// pace: an item that causes k results holds the output until all k are taken (k is at
// most 3, for the last character of a name: label byte, length byte, zero byte); items
// with zero or one result flow at one per cycle while results are taken. No memory, no
// clearing pass after reset. Depends on dnw_pkg, dnw_if, dnw_parse and dnw_drain.
module dns_name_text_to_wire_core
   import dnw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dnw_req_if.sink     req_bus,
   dnw_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration register
   logic fold_case_ff, fold_case_in;
   logic csr_write;
   logic csr_hit;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;

   logic       take;
   logic       can_load;
   logic       load;
   bundle_type bundle;

   // decode: word index is bit 2 of the byte address
   assign csr_hit    = (csr_paddr[2] == REG_FOLD_CASE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {31'd0, fold_case_ff} : 32'd0;

   always_comb begin
      fold_case_in = fold_case_ff;
      if (csr_write && csr_hit) begin
         fold_case_in = csr_pwdata[0];
      end
   end

   // advance the held item into the parser when the result register can take its bundle
   assign take          = in_valid_ff && can_load;
   assign req_bus.ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in            = 1'b1;
         in_item_in.char_byte   = req_bus.char_byte;
         in_item_in.end_of_name = req_bus.end_of_name;
         in_item_in.no_char     = req_bus.no_char;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (reset) begin
         fold_case_ff <= 1'b0;
         in_valid_ff  <= 1'b0;
      end else begin
         fold_case_ff <= fold_case_in;
         in_valid_ff  <= in_valid_in;
      end
   end

   dnw_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fold_case (fold_case_ff),
      .take      (take),
      .item      (in_item_ff),
      .bundle    (bundle)
   );

   // drop empty bundles: items that cause no result just retire
   assign load = take && (bundle.count != 2'd0);

   dnw_drain u_drain (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .bundle   (bundle),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

endmodule
